// File: design/vdi_pkg.sv
package vdi_pkg;

   typedef logic [31:0] word_type;

   localparam int        PORT_COMPS     = 8;
   localparam int        CSR_W          = 4;
   localparam int        INDEX_W        = 10;
   localparam word_type  NEG_ZERO       = 32'h8000_0000;
   localparam logic [CSR_W-1:0] KEY_LEN_RESET = 4'd8;

   function automatic word_type fold_zero(input word_type value);
      word_type result;
      result = (value == NEG_ZERO) ? '0 : value;
      return result;
   endfunction

endpackage

// File: design/vertex_dedup_indexer_unit.sv
// The rsp_valid strobe follows the start transfer once the scan ends: at the first stored entry
// that matches, or after every stored entry has been compared (with no compare when empty).
// The next start transfer is taken in the strobe cycle; a single comparator checks one stored
// entry per cycle, busy is high meanwhile.
// Reset (synchronous, active high) empties the table and sets the key length to 8.
// Results are strobed for one cycle; the receiver cannot stall.
module vertex_dedup_indexer_unit #(
   parameter int MAX_VERTICES   = 1024,
   parameter int MAX_COMPONENTS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_start_of_mesh,
   input  vdi_pkg::word_type              req_comp0,
   input  vdi_pkg::word_type              req_comp1,
   input  vdi_pkg::word_type              req_comp2,
   input  vdi_pkg::word_type              req_comp3,
   input  vdi_pkg::word_type              req_comp4,
   input  vdi_pkg::word_type              req_comp5,
   input  vdi_pkg::word_type              req_comp6,
   input  vdi_pkg::word_type              req_comp7,
   output logic                           rsp_valid,
   output logic [vdi_pkg::INDEX_W-1:0]    rsp_vert_id,
   output logic                           rsp_is_new,
   output logic                           rsp_table_full,
   input  logic                           csr_we,
   input  logic [vdi_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int KEY_W  = MAX_COMPONENTS * 32;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic                       state_ff, state_in;
   logic [vdi_pkg::CSR_W-1:0]  key_len_ff, key_len_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           issue_ff, issue_in;
   logic                       pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]           pend_idx_ff, pend_idx_in;
   logic [KEY_W-1:0]           key_ff, key_in;
   logic [MAX_COMPONENTS-1:0]  mask_ff, mask_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [vdi_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                       rsp_new_ff, rsp_new_in;
   logic                       rsp_full_ff, rsp_full_in;

   vdi_pkg::word_type          req_comps [vdi_pkg::PORT_COMPS];
   logic [vdi_pkg::CSR_W-1:0]  eff_len;
   logic                       accept;
   logic                       match;
   logic [KEY_W-1:0]           rd_data;
   logic                       wr_en;

   assign req_comps[0] = req_comp0;
   assign req_comps[1] = req_comp1;
   assign req_comps[2] = req_comp2;
   assign req_comps[3] = req_comp3;
   assign req_comps[4] = req_comp4;
   assign req_comps[5] = req_comp5;
   assign req_comps[6] = req_comp6;
   assign req_comps[7] = req_comp7;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      if (key_len_ff == '0) begin
         eff_len = vdi_pkg::CSR_W'(1);
      end else if (key_len_ff > vdi_pkg::CSR_W'(MAX_COMPONENTS)) begin
         eff_len = vdi_pkg::CSR_W'(MAX_COMPONENTS);
      end else begin
         eff_len = key_len_ff;
      end
      for (int c = 0; c < MAX_COMPONENTS; c++) begin
         key_in[c*32 +: 32] = vdi_pkg::fold_zero(req_comps[c]);
         mask_in[c]         = (vdi_pkg::CSR_W'(c) < eff_len);
      end
   end

   vdi_store #(
      .DEPTH  (MAX_VERTICES),
      .WIDTH  (KEY_W),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   vdi_cmp #(
      .COMPS (MAX_COMPONENTS)
   ) u_cmp (
      .entry (rd_data),
      .key   (key_ff),
      .mask  (mask_ff),
      .match (match)
   );

   always_comb begin
      state_in     = state_ff;
      key_len_in   = csr_we ? csr_wdata : key_len_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      pend_vld_in  = 1'b0;
      pend_idx_in  = issue_ff[IDX_W-1:0];
      rsp_valid_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      wr_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               issue_in = '0;
               if (req_start_of_mesh) begin
                  count_in = '0;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff < count_ff) begin
               pend_vld_in = 1'b1;
               issue_in    = issue_ff + 1'b1;
            end
            if (pend_vld_ff && match) begin
               state_in     = S_IDLE;
               pend_vld_in  = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_index_in = vdi_pkg::INDEX_W'(pend_idx_ff);
               rsp_new_in   = 1'b0;
               rsp_full_in  = 1'b0;
            end else if (!pend_vld_ff && (issue_ff >= count_ff)) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (count_ff >= CNT_W'(MAX_VERTICES)) begin
                  rsp_index_in = '0;
                  rsp_new_in   = 1'b0;
                  rsp_full_in  = 1'b1;
               end else begin
                  wr_en        = 1'b1;
                  count_in     = count_ff + 1'b1;
                  rsp_index_in = vdi_pkg::INDEX_W'(count_ff[IDX_W-1:0]);
                  rsp_new_in   = 1'b1;
                  rsp_full_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_len_ff   <= vdi_pkg::KEY_LEN_RESET;
         count_ff     <= '0;
         issue_ff     <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_len_ff   <= key_len_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff  <= pend_idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_full_ff  <= rsp_full_in;
      if (accept) begin
         key_ff  <= key_in;
         mask_ff <= mask_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_vert_id    = rsp_index_ff;
   assign rsp_is_new     = rsp_new_ff;
   assign rsp_table_full = rsp_full_ff;

endmodule

// File: design/vdi_cmp.sv
module vdi_cmp #(
   parameter int COMPS = 8
) (
   input  logic [COMPS*32-1:0] entry,
   input  logic [COMPS*32-1:0] key,
   input  logic [COMPS-1:0]    mask,
   output logic                match
);

   logic [COMPS-1:0] lane_ok;

   always_comb begin
      for (int c = 0; c < COMPS; c++) begin
         lane_ok[c] = !mask[c] || (entry[c*32 +: 32] == key[c*32 +: 32]);
      end
   end

   assign match = &lane_ok;

endmodule

// File: design/vdi_store.sv
module vdi_store #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 256,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/vdi_chk.sv
module vdi_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [vdi_pkg::INDEX_W-1:0] rsp_vert_id,
   input logic                        rsp_is_new,
   input logic                        rsp_table_full
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while still busy");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_new && rsp_table_full))
      else $error("new and full flagged together");

   a_full_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (rsp_vert_id == '0))
      else $error("full result with nonzero index");

endmodule

bind vertex_dedup_indexer_unit vdi_chk u_vdi_chk (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_vert_id    (rsp_vert_id),
   .rsp_is_new     (rsp_is_new),
   .rsp_table_full (rsp_table_full)
);

// File: sim/vertex_dedup_indexer_unit_tb.sv
module vertex_dedup_indexer_unit_tb;

   localparam int     MAX_VERTICES  = 1024;
   localparam int     KEY_WORDS     = vdi_pkg::PORT_COMPS;
   localparam int     DIRECTED_ROWS = 18;
   localparam int     EARLY_ITEMS   = 350;
   localparam int     TOTAL_ITEMS   = 1750;
   localparam int     FILL_OVERFLOW = 40;
   localparam longint CYCLE_LIMIT   = 6_000_000;

   typedef struct packed {
      logic                                som;
      vdi_pkg::word_type [KEY_WORDS-1:0]   comp;
   } vertex_type;

   typedef struct packed {
      logic [vdi_pkg::INDEX_W-1:0] index;
      logic                        is_new;
      logic                        full;
   } lookup_type;

   typedef struct packed {
      logic                      has_cfg;
      logic [vdi_pkg::CSR_W-1:0] cfg;
      logic                      som;
      vdi_pkg::word_type         lo;
      vdi_pkg::word_type         hi;
      logic                      typed;
      lookup_type                want;
   } row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_start_of_mesh = 1'b0;
   vdi_pkg::word_type req_comp0 = '0;
   vdi_pkg::word_type req_comp1 = '0;
   vdi_pkg::word_type req_comp2 = '0;
   vdi_pkg::word_type req_comp3 = '0;
   vdi_pkg::word_type req_comp4 = '0;
   vdi_pkg::word_type req_comp5 = '0;
   vdi_pkg::word_type req_comp6 = '0;
   vdi_pkg::word_type req_comp7 = '0;
   logic                         rsp_valid;
   logic [vdi_pkg::INDEX_W-1:0]  rsp_vert_id;
   logic                         rsp_is_new;
   logic                         rsp_table_full;
   logic                         csr_we = 1'b0;
   logic [vdi_pkg::CSR_W-1:0]    csr_wdata = '0;

   vdi_pkg::word_type         table_keys [MAX_VERTICES][KEY_WORDS];
   int unsigned               table_count = 0;
   logic [vdi_pkg::CSR_W-1:0] key_len_reg = vdi_pkg::KEY_LEN_RESET;
   lookup_type                pending_lookups [$];
   vertex_type                mesh_history [$];
   vertex_type                fill_history [$];
   row_type                   directed [DIRECTED_ROWS];
   int                        fail_count = 0;
   int                        sent_count = 0;
   longint                    cycle_count = 0;
   bit                        burst = 1'b0;

   vertex_dedup_indexer_unit #(
      .MAX_VERTICES   (MAX_VERTICES),
      .MAX_COMPONENTS (KEY_WORDS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_start_of_mesh (req_start_of_mesh),
      .req_comp0         (req_comp0),
      .req_comp1         (req_comp1),
      .req_comp2         (req_comp2),
      .req_comp3         (req_comp3),
      .req_comp4         (req_comp4),
      .req_comp5         (req_comp5),
      .req_comp6         (req_comp6),
      .req_comp7         (req_comp7),
      .rsp_valid         (rsp_valid),
      .rsp_vert_id       (rsp_vert_id),
      .rsp_is_new        (rsp_is_new),
      .rsp_table_full    (rsp_table_full),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic lookup_type lookup_vertex(input vertex_type v);
      vdi_pkg::word_type key [KEY_WORDS];
      int                n;
      bit                same;
      lookup_type        r;
      n = (key_len_reg == 0) ? 1 : (key_len_reg > KEY_WORDS) ? KEY_WORDS : int'(key_len_reg);
      if (v.som) table_count = 0;
      for (int c = 0; c < KEY_WORDS; c++)
         key[c] = (v.comp[c] == vdi_pkg::NEG_ZERO) ? '0 : v.comp[c];
      for (int i = 0; i < int'(table_count); i++) begin
         same = 1'b1;
         for (int c = 0; c < n; c++)
            if (table_keys[i][c] != key[c]) same = 1'b0;
         if (same) begin
            r.index  = vdi_pkg::INDEX_W'(i);
            r.is_new = 1'b0;
            r.full   = 1'b0;
            return r;
         end
      end
      if (table_count >= MAX_VERTICES) begin
         r.index  = '0;
         r.is_new = 1'b0;
         r.full   = 1'b1;
         return r;
      end
      for (int c = 0; c < KEY_WORDS; c++)
         table_keys[table_count][c] = key[c];
      r.index  = vdi_pkg::INDEX_W'(table_count);
      r.is_new = 1'b1;
      r.full   = 1'b0;
      table_count++;
      return r;
   endfunction

   function automatic row_type mk_row(input bit has_cfg, input int cfg, input bit som,
                                      input vdi_pkg::word_type lo,
                                      input vdi_pkg::word_type hi,
                                      input bit typed, input int idx, input bit is_new);
      row_type r;
      r.has_cfg     = has_cfg;
      r.cfg         = vdi_pkg::CSR_W'(cfg);
      r.som         = som;
      r.lo          = lo;
      r.hi          = hi;
      r.typed       = typed;
      r.want.index  = vdi_pkg::INDEX_W'(idx);
      r.want.is_new = is_new;
      r.want.full   = 1'b0;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic vdi_pkg::word_type pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return vdi_pkg::NEG_ZERO;
         2: return vdi_pkg::word_type'($urandom_range(0, 3));
         3: return 32'h7fc0_0000 | vdi_pkg::word_type'($urandom_range(0, 3));
         default: return $urandom;
      endcase
   endfunction

   // pick an earlier vertex of this mesh, swap signed zeros, sometimes alter one word
   function automatic vertex_type reuse_vertex();
      vertex_type v;
      v = mesh_history[$urandom_range(0, mesh_history.size() - 1)];
      for (int c = 0; c < KEY_WORDS; c++)
         if ((v.comp[c] == '0 || v.comp[c] == vdi_pkg::NEG_ZERO) && $urandom_range(0, 1))
            v.comp[c] = (v.comp[c] == '0) ? vdi_pkg::NEG_ZERO : '0;
      if ($urandom_range(0, 2) == 0)
         v.comp[$urandom_range(0, KEY_WORDS - 1)] = pick_word();
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   task automatic send_vertex(input vertex_type v, input bit typed, input lookup_type want);
      int         gap;
      lookup_type predicted;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_start_of_mesh <= v.som;
      req_comp0         <= v.comp[0];
      req_comp1         <= v.comp[1];
      req_comp2         <= v.comp[2];
      req_comp3         <= v.comp[3];
      req_comp4         <= v.comp[4];
      req_comp5         <= v.comp[5];
      req_comp6         <= v.comp[6];
      req_comp7         <= v.comp[7];
      do @(posedge clock); while (busy);
      predicted = lookup_vertex(v);
      pending_lookups.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   // key length changes only with the table walk drained
   task automatic write_key_len(input logic [vdi_pkg::CSR_W-1:0] value);
      start <= 1'b0;
      do @(posedge clock); while (pending_lookups.size() != 0 || busy);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we      <= 1'b0;
      key_len_reg = value;
   endtask

   task automatic run_small_meshes(input int upto);
      vertex_type v;
      int         mesh_len;
      while (sent_count < upto) begin
         burst = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) == 0)
            write_key_len(vdi_pkg::CSR_W'($urandom_range(0, 15)));
         mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                                : $urandom_range(1, 40);
         mesh_history.delete();
         for (int k = 0; k < mesh_len && sent_count < upto; k++) begin
            if (k > 0 && $urandom_range(0, 31) == 0)
               write_key_len(vdi_pkg::CSR_W'($urandom_range(0, 15)));
            if (mesh_history.size() > 0 && $urandom_range(0, 1))
               v = reuse_vertex();
            else
               for (int c = 0; c < KEY_WORDS; c++) v.comp[c] = pick_word();
            v.som = (k == 0) || ($urandom_range(0, 63) == 0);
            send_vertex(v, 1'b0, '0);
            mesh_history.push_back(v);
         end
      end
   endtask

   // fill every slot, then push hits and misses against the full table
   task automatic fill_table();
      vertex_type v;
      burst = 1'b0;
      write_key_len(vdi_pkg::CSR_W'($urandom_range(1, 8)));
      fill_history.delete();
      for (int i = 0; i < MAX_VERTICES; i++) begin
         for (int c = 0; c < KEY_WORDS; c++) v.comp[c] = $urandom;
         v.comp[0][vdi_pkg::INDEX_W-1:0] = vdi_pkg::INDEX_W'(i);
         v.som = (i == 0);
         send_vertex(v, 1'b0, '0);
         fill_history.push_back(v);
      end
      for (int k = 0; k < FILL_OVERFLOW; k++) begin
         if (k == FILL_OVERFLOW / 2)
            write_key_len(vdi_pkg::CSR_W'($urandom_range(0, 15)));
         if ($urandom_range(0, 1))
            v = fill_history[$urandom_range(0, fill_history.size() - 1)];
         else
            for (int c = 0; c < KEY_WORDS; c++) v.comp[c] = pick_word();
         v.som = 1'b0;
         send_vertex(v, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      lookup_type want;
      if (!reset && rsp_valid) begin
         if (pending_lookups.size() == 0) begin
            report_mismatch($sformatf("result index %0d with no transfer pending",
                                      rsp_vert_id));
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_vert_id !== want.index)
               report_mismatch($sformatf("vert_id got %0d want %0d",
                                         rsp_vert_id, want.index));
            if (rsp_is_new !== want.is_new)
               report_mismatch($sformatf("is_new got %0b want %0b", rsp_is_new, want.is_new));
            if (rsp_table_full !== want.full)
               report_mismatch($sformatf("table_full got %0b want %0b",
                                         rsp_table_full, want.full));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("vertex_dedup_indexer_unit verification failed");
         $finish;
      end
   end

   initial begin
      vertex_type v;
      //                  cfg?  len  som  lo            hi            typed idx new
      directed[0]  = mk_row(0, 0,  1, 32'h0000_0000, 32'h0000_0000, 1, 0, 1);
      directed[1]  = mk_row(0, 0,  0, 32'h8000_0000, 32'h8000_0000, 1, 0, 0);
      directed[2]  = mk_row(0, 0,  0, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 1);
      directed[3]  = mk_row(0, 0,  0, 32'h7fc0_0000, 32'h0000_0000, 1, 2, 1);
      directed[4]  = mk_row(0, 0,  0, 32'h7fc0_0000, 32'h8000_0000, 1, 2, 0);
      directed[5]  = mk_row(0, 0,  0, 32'hffc0_0000, 32'h0000_0000, 1, 3, 1);
      directed[6]  = mk_row(1, 1,  0, 32'h0000_0000, 32'h1234_5678, 0, 0, 0);
      directed[7]  = mk_row(1, 0,  0, 32'hffff_ffff, 32'h0000_0000, 0, 0, 0);
      directed[8]  = mk_row(1, 15, 0, 32'hffff_ffff, 32'h0000_0000, 0, 0, 0);
      directed[9]  = mk_row(1, 9,  0, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0);
      directed[10] = mk_row(1, 4,  0, 32'hffff_ffff, 32'h0000_0001, 0, 0, 0);
      directed[11] = mk_row(0, 0,  0, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0);
      directed[12] = mk_row(1, 8,  1, 32'hffff_ffff, 32'hffff_ffff, 1, 0, 1);
      directed[13] = mk_row(0, 0,  0, 32'haaaa_aaaa, 32'h5555_5555, 1, 1, 1);
      directed[14] = mk_row(0, 0,  0, 32'h5555_5555, 32'haaaa_aaaa, 1, 2, 1);
      directed[15] = mk_row(0, 0,  0, 32'h7f80_0000, 32'hff80_0000, 0, 0, 0);
      directed[16] = mk_row(0, 0,  1, 32'haaaa_aaaa, 32'h5555_5555, 1, 0, 1);
      directed[17] = mk_row(1, 2,  0, 32'h5555_5555, 32'h0000_0000, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < DIRECTED_ROWS; k++) begin
         if (directed[k].has_cfg) write_key_len(directed[k].cfg);
         v.som = directed[k].som;
         for (int c = 0; c < KEY_WORDS; c++)
            v.comp[c] = (c < KEY_WORDS / 2) ? directed[k].lo : directed[k].hi;
         send_vertex(v, directed[k].typed, directed[k].want);
      end

      run_small_meshes(EARLY_ITEMS);
      fill_table();
      run_small_meshes(TOTAL_ITEMS);

      start <= 1'b0;
      do @(posedge clock); while (pending_lookups.size() != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("vertex_dedup_indexer_unit verification clean");
      end else begin
         $display("vertex_dedup_indexer_unit verification failed");
      end
      $finish;
   end

endmodule
